/* hw/rtl/cdft_pkg.sv */
`timescale 1ns / 1ps

package cdft_pkg;

  localparam int POINTS_DEF = 16;
  localparam int SAMPLE_W   = 16;
  localparam int BIN_W      = 24;
  localparam int INDEX_W    = 6;
  localparam int ACC_W      = 40;
  localparam int MAG_W      = 23;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PIH_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [BIN_W-1:0]    bin_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Rounds a Q2.30 series sum to Q1.15, clamped to the range [0, 32767].
  function automatic sample_t round_q15(input logic signed [63:0] acc);
    logic signed [63:0] a;
    logic signed [63:0] r;
    a = acc;
    if (a < 0) begin
      a = 64'sd0;
    end
    r = (a + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return sample_t'(r);
  endfunction

  // Cosine of a Q2.30 angle in the first quadrant by Taylor series.
  function automatic sample_t cos_q15(input logic [63:0] x);
    logic [63:0]        t;
    logic signed [63:0] acc;
    t   = ONE_Q30;
    acc = signed'(t);
    t   = ((t * x) >> 30) / 64'd2;
    acc = acc - signed'(t);
    t   = ((t * x) >> 30) / 64'd12;
    acc = acc + signed'(t);
    t   = ((t * x) >> 30) / 64'd30;
    acc = acc - signed'(t);
    t   = ((t * x) >> 30) / 64'd56;
    acc = acc + signed'(t);
    t   = ((t * x) >> 30) / 64'd90;
    acc = acc - signed'(t);
    t   = ((t * x) >> 30) / 64'd132;
    acc = acc + signed'(t);
    return round_q15(acc);
  endfunction

  // Sine of a Q2.30 angle in the first quadrant by Taylor series.
  function automatic sample_t sin_q15(input logic [63:0] x);
    logic [63:0]        t;
    logic signed [63:0] acc;
    t   = x;
    acc = signed'(t);
    t   = ((t * x) >> 30) / 64'd6;
    acc = acc - signed'(t);
    t   = ((t * x) >> 30) / 64'd20;
    acc = acc + signed'(t);
    t   = ((t * x) >> 30) / 64'd42;
    acc = acc - signed'(t);
    t   = ((t * x) >> 30) / 64'd72;
    acc = acc + signed'(t);
    t   = ((t * x) >> 30) / 64'd110;
    acc = acc - signed'(t);
    t   = ((t * x) >> 30) / 64'd156;
    acc = acc + signed'(t);
    return round_q15(acc);
  endfunction

endpackage

/* hw/rtl/complex_dft_forward_inverse_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// in_       input      in_tvalid / in_tready     sample_real, sample_imag
// out_      output     out_tvalid / out_tready   bin_real, bin_imag, bin_index, last_bin
// cfg_      input      cfg_wr_en                 inverse_mode
//
// A frame takes POINTS input transactions at one per cycle, then the single complex
// multiply-accumulate unit forms one term per cycle while the output is not stalled,
// POINTS terms per bin, and each bin passes the final-sum, magnitude, quotient and
// output registers. Input is not accepted while the terms are being issued.
// A stalled output freezes the whole multiply-accumulate and scaling pipeline.
// Reset clears the sequencer, the fill counter, the pipeline valids and the mode.
module complex_dft_forward_inverse_core #(
  parameter int POINTS = cdft_pkg::POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // sample_real [15:0], sample_imag [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // bin_real [23:0], bin_imag [47:24], bin_index [53:48]
  output logic        out_tlast,   // last_bin
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data  // inverse_mode
);

  localparam int IW = $clog2(POINTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(POINTS - 1);
  localparam logic [IW:0]   NPTS     = (IW + 1)'(POINTS);
  localparam int RSH = cdft_pkg::MAG_W + IW;
  localparam longint unsigned RECIP_V = ((64'd1 << RSH) + POINTS - 1) / POINTS;
  localparam logic [cdft_pkg::MAG_W:0] RECIP = (cdft_pkg::MAG_W + 1)'(RECIP_V);

  localparam logic ST_FILL = 1'b0;
  localparam logic ST_CALC = 1'b1;

  cdft_pkg::sample_t tw_cos [POINTS];
  cdft_pkg::sample_t tw_sin [POINTS];

  for (genvar gm = 0; gm < POINTS; gm++) begin : g_rom
    localparam int unsigned TQ = (4 * gm) / POINTS;
    localparam longint unsigned TR = (4 * gm) % POINTS;
    localparam logic [63:0] TX = (cdft_pkg::PIH_Q30 * TR) / POINTS;
    localparam cdft_pkg::sample_t TC = cdft_pkg::cos_q15(TX);
    localparam cdft_pkg::sample_t TS = cdft_pkg::sin_q15(TX);
    localparam cdft_pkg::sample_t RC = (TQ == 0) ? TC : (TQ == 1) ? -TS :
                                       (TQ == 2) ? -TC : TS;
    localparam cdft_pkg::sample_t RS = (TQ == 0) ? TS : (TQ == 1) ? TC :
                                       (TQ == 2) ? -TS : -TC;
    assign tw_cos[gm] = RC;
    assign tw_sin[gm] = RS;
  end

  logic [31:0] mem [POINTS];

  logic          state_r, state_nxt;
  logic [IW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] n_r, n_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] m_r, m_nxt;
  logic [IW:0]   m_sum;
  logic          inv_r, inv_nxt;
  logic          mode_r;

  logic          en;
  logic          issue;
  logic          in_acc;

  // Stage 1: sample and twiddle.
  logic              v1_r, first1_r, last1_r, inv1_r;
  logic [IW-1:0]     k1_r;
  logic [31:0]       smp_r;
  cdft_pkg::sample_t c_r, d_r;
  // Stage 2: products.
  logic              v2_r, first2_r, last2_r, inv2_r;
  logic [IW-1:0]     k2_r;
  logic signed [31:0] p_ac_r, p_bd_r, p_ad_r, p_bc_r;
  // Stage 3: accumulation.
  cdft_pkg::acc_t    acc_re_r, acc_im_r;
  cdft_pkg::acc_t    sum_re, sum_im, base_re, base_im;
  logic              vf_r, invf_r;
  logic [IW-1:0]     kf_r;
  cdft_pkg::acc_t    fin_re_r, fin_im_r;
  // Scaling stages.
  logic              vc1_r, sgn_re1_r, sgn_im1_r, invc1_r;
  logic [IW-1:0]     kc1_r;
  logic [cdft_pkg::MAG_W-1:0] mag_re_r, mag_im_r;
  cdft_pkg::acc_t    abs_re, abs_im;
  logic              vc2_r, sgn_re2_r, sgn_im2_r;
  logic [IW-1:0]     kc2_r;
  logic [cdft_pkg::MAG_W-1:0] q_re_r, q_im_r;
  logic [2*cdft_pkg::MAG_W:0] prod_re, prod_im;
  // Output register.
  logic              out_valid_r, out_last_r;
  cdft_pkg::bin_t    out_re_r, out_im_r;
  logic [cdft_pkg::INDEX_W-1:0] out_idx_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_FILL);
  assign in_acc    = in_tvalid && in_tready;
  assign issue     = (state_r == ST_CALC) && en;

  assign m_sum = {1'b0, m_r} + {1'b0, k_r};

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    inv_nxt   = inv_r;
    case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (fill_r == LAST_IDX) begin
            fill_nxt  = '0;
            state_nxt = ST_CALC;
            n_nxt     = '0;
            k_nxt     = '0;
            m_nxt     = '0;
            inv_nxt   = mode_r;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
        end
      end
      ST_CALC: begin
        if (issue) begin
          if (n_r == LAST_IDX) begin
            n_nxt = '0;
            m_nxt = '0;
            if (k_r == LAST_IDX) begin
              state_nxt = ST_FILL;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end else begin
            n_nxt = n_r + 1'b1;
            m_nxt = (m_sum >= NPTS) ? IW'(m_sum - NPTS) : IW'(m_sum);
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_r      <= '0;
      n_r         <= '0;
      k_r         <= '0;
      m_r         <= '0;
      inv_r       <= 1'b0;
      mode_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vf_r        <= 1'b0;
      vc1_r       <= 1'b0;
      vc2_r       <= 1'b0;
      out_valid_r <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      m_r     <= m_nxt;
      inv_r   <= inv_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (en) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        vf_r        <= v2_r && last2_r;
        vc1_r       <= vf_r;
        vc2_r       <= vc1_r;
        out_valid_r <= vc2_r;
        if (v2_r) begin
          acc_re_r <= sum_re;
          acc_im_r <= sum_im;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem[fill_r] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp_r <= mem[n_r];
    end
  end

  assign base_re = first2_r ? '0 : acc_re_r;
  assign base_im = first2_r ? '0 : acc_im_r;
  assign sum_re  = base_re + cdft_pkg::ACC_W'(p_ac_r) - cdft_pkg::ACC_W'(p_bd_r);
  assign sum_im  = base_im + cdft_pkg::ACC_W'(p_ad_r) + cdft_pkg::ACC_W'(p_bc_r);

  assign abs_re = fin_re_r[cdft_pkg::ACC_W-1] ? -fin_re_r : fin_re_r;
  assign abs_im = fin_im_r[cdft_pkg::ACC_W-1] ? -fin_im_r : fin_im_r;

  assign prod_re = (2 * cdft_pkg::MAG_W + 1)'(mag_re_r * RECIP);
  assign prod_im = (2 * cdft_pkg::MAG_W + 1)'(mag_im_r * RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      first1_r <= (n_r == '0);
      last1_r  <= (n_r == LAST_IDX);
      inv1_r   <= inv_r;
      k1_r     <= k_r;
      c_r      <= tw_cos[m_r];
      d_r      <= inv_r ? tw_sin[m_r] : -tw_sin[m_r];

      first2_r <= first1_r;
      last2_r  <= last1_r;
      inv2_r   <= inv1_r;
      k2_r     <= k1_r;
      p_ac_r   <= $signed(smp_r[15:0])  * c_r;
      p_bd_r   <= $signed(smp_r[31:16]) * d_r;
      p_ad_r   <= $signed(smp_r[15:0])  * d_r;
      p_bc_r   <= $signed(smp_r[31:16]) * c_r;

      kf_r     <= k2_r;
      invf_r   <= inv2_r;
      fin_re_r <= sum_re;
      fin_im_r <= sum_im;

      kc1_r     <= kf_r;
      invc1_r   <= invf_r;
      sgn_re1_r <= fin_re_r[cdft_pkg::ACC_W-1];
      sgn_im1_r <= fin_im_r[cdft_pkg::ACC_W-1];
      mag_re_r  <= abs_re[15 +: cdft_pkg::MAG_W];
      mag_im_r  <= abs_im[15 +: cdft_pkg::MAG_W];

      kc2_r     <= kc1_r;
      sgn_re2_r <= sgn_re1_r;
      sgn_im2_r <= sgn_im1_r;
      q_re_r    <= invc1_r ? mag_re_r : cdft_pkg::MAG_W'(prod_re >> RSH);
      q_im_r    <= invc1_r ? mag_im_r : cdft_pkg::MAG_W'(prod_im >> RSH);

      out_idx_r  <= cdft_pkg::INDEX_W'(kc2_r);
      out_last_r <= (kc2_r == LAST_IDX);
      out_re_r   <= sgn_re2_r ? -cdft_pkg::BIN_W'(q_re_r) : cdft_pkg::BIN_W'(q_re_r);
      out_im_r   <= sgn_im2_r ? -cdft_pkg::BIN_W'(q_im_r) : cdft_pkg::BIN_W'(q_im_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_idx_r, out_im_r, out_re_r};

endmodule

/* tb/cdft_bin_checker.sv */
`timescale 1ns / 1ps

module cdft_bin_checker #(
  parameter int POINTS = cdft_pkg::POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int          error_count,
  output int          pending_bins
);

  typedef struct packed {
    cdft_pkg::bin_t               re;
    cdft_pkg::bin_t               im;
    logic [cdft_pkg::INDEX_W-1:0] idx;
    logic                         last;
  } bin_rec_t;

  int                tw_cos [POINTS];
  int                tw_sin [POINTS];
  cdft_pkg::sample_t frame_re [POINTS];
  cdft_pkg::sample_t frame_im [POINTS];
  int                fill_level;
  logic              inverse_sel;
  bin_rec_t          expected_bins [$];
  bin_rec_t          want;
  cdft_pkg::bin_t    got_re;
  cdft_pkg::bin_t    got_im;

  function automatic int taylor_q15(input longint unsigned ang, input bit want_cos);
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    bit              sub;
    term = want_cos ? longint'(cdft_pkg::ONE_Q30) : ang;
    n    = want_cos ? 0 : 1;
    sum  = longint'(term);
    sub  = 1'b1;
    while (n < 12) begin
      term = ((term * ang) >> 30) / ((n + 1) * (n + 2));
      n    = n + 2;
      sum  = sub ? sum - longint'(term) : sum + longint'(term);
      sub  = !sub;
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32767) begin
      sum = 32767;
    end
    return int'(sum);
  endfunction

  function automatic cdft_pkg::bin_t clamp_bin(input longint v);
    if (v > 64'sd8388607) begin
      return cdft_pkg::bin_t'(24'h7fffff);
    end
    if (v < -64'sd8388608) begin
      return cdft_pkg::bin_t'(24'h800000);
    end
    return cdft_pkg::bin_t'(v);
  endfunction

  task automatic predict_frame(input logic inv);
    longint acc_re;
    longint acc_im;
    longint a;
    longint b;
    longint c;
    longint d;
    longint div;
    int     m;
    bin_rec_t rec;
    div = inv ? 64'sd32768 : longint'(POINTS) * 64'sd32768;
    for (int k = 0; k < POINTS; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (int n = 0; n < POINTS; n++) begin
        m = (k * n) % POINTS;
        a = frame_re[n];
        b = frame_im[n];
        c = tw_cos[m];
        d = inv ? longint'(tw_sin[m]) : -longint'(tw_sin[m]);
        acc_re = acc_re + a * c - b * d;
        acc_im = acc_im + a * d + b * c;
      end
      rec.re   = clamp_bin(acc_re / div);
      rec.im   = clamp_bin(acc_im / div);
      rec.idx  = cdft_pkg::INDEX_W'(k);
      rec.last = (k == POINTS - 1);
      expected_bins.push_back(rec);
    end
  endtask

  initial begin : build_twiddles
    int              q;
    int              r;
    int              cv;
    int              sv;
    longint unsigned ang;
    for (int m = 0; m < POINTS; m++) begin
      q   = (4 * m) / POINTS;
      r   = (4 * m) % POINTS;
      ang = (longint'(cdft_pkg::PIH_Q30) * longint'(r)) / longint'(POINTS);
      cv  = taylor_q15(ang, 1'b1);
      sv  = taylor_q15(ang, 1'b0);
      case (q % 4)
        0: begin
          tw_cos[m] = cv;
          tw_sin[m] = sv;
        end
        1: begin
          tw_cos[m] = -sv;
          tw_sin[m] = cv;
        end
        2: begin
          tw_cos[m] = -cv;
          tw_sin[m] = -sv;
        end
        default: begin
          tw_cos[m] = sv;
          tw_sin[m] = -cv;
        end
      endcase
    end
  end

  initial begin
    error_count  = 0;
    pending_bins = 0;
    fill_level   = 0;
    inverse_sel  = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_level  = 0;
      inverse_sel = 1'b0;
      expected_bins.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_bins.size() == 0) begin
          $error("unexpected bin transaction: bin_index %0d", out_tdata[53:48]);
          error_count++;
        end else begin
          want   = expected_bins.pop_front();
          got_re = out_tdata[23:0];
          got_im = out_tdata[47:24];
          if (got_re !== want.re) begin
            $error("bin_real: expected %0d, actual %0d", want.re, got_re);
            error_count++;
          end
          if (got_im !== want.im) begin
            $error("bin_imag: expected %0d, actual %0d", want.im, got_im);
            error_count++;
          end
          if (out_tdata[53:48] !== want.idx) begin
            $error("bin_index: expected %0d, actual %0d", want.idx, out_tdata[53:48]);
            error_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_bin: expected %0d, actual %0d", want.last, out_tlast);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        frame_re[fill_level] = in_tdata[15:0];
        frame_im[fill_level] = in_tdata[31:16];
        fill_level++;
        if (fill_level == POINTS) begin
          fill_level = 0;
          predict_frame(inverse_sel);
        end
      end
      if (cfg_wr_en) begin
        inverse_sel = cfg_wr_data;
      end
    end
    pending_bins = expected_bins.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 24;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  int          error_count;
  int          pending_bins;
  int          burst_left;
  int          sent;
  int          phase_len;

  complex_dft_forward_inverse_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cdft_bin_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .error_count  (error_count),
    .pending_bins (pending_bins)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #10 clk = ~clk;
    end
  end

  initial begin
    #10000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : out_stall
    int style;
    int span;
    int tick;
    out_tready = 1'b0;
    span = 0;
    tick = 0;
    style = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(10, 200);
      end
      span--;
      tick++;
      case (style)
        0: out_tready = 1'b1;
        1: out_tready = 1'($urandom_range(0, 1));
        2: out_tready = ($urandom_range(0, 7) != 0);
        default: out_tready = ((tick % 16) >= 12);
      endcase
    end
  end

  function automatic logic [15:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) begin
      return 16'($urandom);
    end
    if (sel < 14) begin
      case ($urandom_range(0, 4))
        0: return 16'h7fff;
        1: return 16'h8000;
        2: return 16'h0000;
        3: return 16'hffff;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  task automatic drive_sample(input logic [15:0] re, input logic [15:0] im);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(20, 60);
      endcase
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = {im, re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle_pipeline();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_bins != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_mode(input logic value);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    burst_left  = 0;
    sent        = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // The mode is switched halfway through the first frame; the frame
    // must be transformed with the mode in force when it completes.
    settle_pipeline();
    write_mode(1'b1);
    drive_sample(16'h7fff, 16'h7fff);
    drive_sample(16'h8000, 16'h8000);
    drive_sample(16'h7fff, 16'h8000);
    drive_sample(16'h8000, 16'h7fff);
    drive_sample(16'h0000, 16'h0000);
    drive_sample(16'h0001, 16'hffff);
    drive_sample(16'hffff, 16'h0001);
    drive_sample(16'h5555, 16'haaaa);
    settle_pipeline();
    write_mode(1'b0);
    drive_sample(16'haaaa, 16'h5555);
    drive_sample(16'h7fff, 16'h0000);
    drive_sample(16'h0000, 16'h7fff);
    drive_sample(16'h8000, 16'h0000);
    drive_sample(16'h0000, 16'h8000);
    drive_sample(16'hffff, 16'hffff);
    drive_sample(16'h0001, 16'h0001);
    drive_sample(16'h0064, 16'hff9c);

    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(8, 72);
      settle_pipeline();
      write_mode(1'($urandom_range(0, 1)));
      repeat (phase_len) begin
        drive_sample(pick_value(), pick_value());
        sent++;
      end
    end
    settle_pipeline();

    if (error_count == 0 && pending_bins == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
